@@ hdl/opp_pkg.sv @@
// ----------------------------------------------------------------------------
// opp_pkg
// Shared widths, limits, reset values and register indexes of the onset
// peak picker.
// ----------------------------------------------------------------------------
package opp_pkg;

  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 24;
  localparam int HOP_W     = 13;
  localparam int WLEN_W    = 4;
  localparam int POS_W     = 36;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WINDOW_DEF = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [HOP_W-1:0]   HOP_MAX   = 13'd4096;

  localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST = 4'd2;
  localparam logic [VALUE_W-1:0] MIN_LEVEL_RST  = 32'd6554;
  localparam logic [HOP_W-1:0]   HOP_SIZE_RST   = 13'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_MIN_LEVEL  = 2'd1,
    REG_HOP_SIZE   = 2'd2
  } cfg_reg_t;

endpackage

@@ hdl/opp_cell.sv @@
// ----------------------------------------------------------------------------
// opp_cell
// One tap of the detection value delay line. Holds one value, takes the value
// of its neighbor on each item and checks that value against the window
// center by its own place in the window.
// ----------------------------------------------------------------------------
module opp_cell
  import opp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int IDX        = 0,
  localparam int WW        = $clog2(MAX_WINDOW + 1),
  localparam int IW        = $clog2(2 * MAX_WINDOW)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic               clear,
  input  logic [VALUE_W-1:0] din,
  input  logic [VALUE_W-1:0] center,
  input  logic [WW-1:0]      window,
  output logic [VALUE_W-1:0] value,
  output logic               pass
);

  localparam logic [IW:0] IDX_C = (IW + 1)'(IDX);

  logic [IW:0]        wm1;
  logic [IW:0]        span;
  logic [VALUE_W+1:0] center_x3;
  logic [VALUE_W+1:0] center_x2;
  logic [VALUE_W+1:0] din_x3;
  logic [VALUE_W+1:0] din_x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      if (clear) begin
        value <= '0;
      end else begin
        value <= din;
      end
    end
  end

  always_comb begin
    wm1       = (IW + 1)'(window) - (IW + 1)'(1);
    span      = {wm1[IW-1:0], 1'b0};
    center_x3 = {2'b00, center} + {1'b0, center, 1'b0};
    center_x2 = {1'b0, center, 1'b0};
    din_x3    = {2'b00, din} + {1'b0, din, 1'b0};
    din_x2    = {1'b0, din, 1'b0};
    if (IDX_C < wm1) begin
      pass = (center_x3 >= din_x2);
    end else if ((IDX_C > wm1) && (IDX_C <= span)) begin
      pass = (center_x2 >= din_x3);
    end else begin
      pass = 1'b1;
    end
  end

endmodule

@@ hdl/opp_out_buf.sv @@
// ----------------------------------------------------------------------------
// opp_out_buf
// Two-entry output buffer: an output register and a skid register, so the
// input side keeps taking items while a result waits downstream.
// ----------------------------------------------------------------------------
module opp_out_buf
  import opp_pkg::*;
#(
  parameter int W = POS_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         head_valid;
  logic         skid_valid;
  logic [W-1:0] head;
  logic [W-1:0] skid;
  logic         pop;

  assign pop       = head_valid & out_ready;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && push) begin
        if (skid_valid) begin
          head <= skid;
          skid <= push_data;
        end else begin
          head <= push_data;
        end
      end else if (pop) begin
        head       <= skid;
        head_valid <= skid_valid;
        skid_valid <= 1'b0;
      end else if (push) begin
        if (!head_valid) begin
          head       <= push_data;
          head_valid <= 1'b1;
        end else begin
          skid       <= push_data;
          skid_valid <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/onset_peak_picker_core.sv @@
// ----------------------------------------------------------------------------
// onset_peak_picker_core
// Sliding-window peak picker on an onset detection function.
// ----------------------------------------------------------------------------
// Takes one detection value (unsigned Q16.16) per clock cycle and decides
// the frame window-1 items back in the same cycle, window being window_len
// clamped to 2..MAX_WINDOW; an onset position (frame index times hop_size
// capped at HOP_MAX) is queued in a two-entry output buffer. The delay line
// is a row of 2*MAX_WINDOW-1 cells, each comparing the value it takes
// against the window center in parallel, so one item is taken every cycle
// while in_ready is high. Input stalls only while both buffer entries are
// held by a stalled downstream. The first item of each stream reports
// position 0, and an item marked last ends the stream without a decision.
// ----------------------------------------------------------------------------
module onset_peak_picker_core
  import opp_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int DEPTH     = 2 * MAX_WINDOW - 1,
  localparam int WW        = $clog2(MAX_WINDOW + 1),
  localparam int IW        = $clog2(2 * MAX_WINDOW)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VALUE_W-1:0]   odf_value,
  input  logic                 last_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     onset_position
);

  logic [WLEN_W-1:0]  window_len;
  logic [VALUE_W-1:0] min_level;
  logic [HOP_W-1:0]   hop_size;
  logic [COUNT_W-1:0] frame_count;

  logic [VALUE_W-1:0] cell_din   [DEPTH];
  logic [VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_pass;

  logic                 accept;
  logic                 buf_full;
  logic [WW-1:0]        window;
  logic [IW-1:0]        center_idx;
  logic [VALUE_W-1:0]   center;
  logic [HOP_W-1:0]     hop;
  logic [COUNT_W-1:0]   min_count;
  logic [COUNT_W-1:0]   frame_idx;
  logic [COUNT_W+HOP_W-1:0] product;
  logic                 peak;
  logic                 push;
  logic [POS_W-1:0]     push_data;

  assign in_ready = ~buf_full;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RST;
      min_level  <= MIN_LEVEL_RST;
      hop_size   <= HOP_SIZE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data[WLEN_W-1:0];
        REG_MIN_LEVEL:  min_level  <= cfg_data;
        REG_HOP_SIZE:   hop_size   <= cfg_data[HOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (accept) begin
      if (last_frame) begin
        frame_count <= '0;
      end else if (frame_count != COUNT_MAX) begin
        frame_count <= frame_count + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    if (window_len < WLEN_W'(2)) begin
      window = WW'(2);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      window = WW'(MAX_WINDOW);
    end else begin
      window = WW'(window_len);
    end
    hop        = (hop_size > HOP_MAX) ? HOP_MAX : hop_size;
    center_idx = IW'(window) - IW'(1);
    center     = cell_din[center_idx];
    min_count  = {(COUNT_W-1)'(window) - (COUNT_W-1)'(1), 1'b0} | COUNT_W'(1);
    frame_idx  = frame_count - (COUNT_W'(window) - COUNT_W'(1));
    product    = (COUNT_W + HOP_W)'(frame_idx) * (COUNT_W + HOP_W)'(hop);
    peak       = (center >= min_level) && (&cell_pass);
    if (frame_count == '0) begin
      push      = accept;
      push_data = '0;
    end else begin
      push      = accept && !last_frame && (frame_count != COUNT_MAX)
                  && (frame_count >= min_count) && peak;
      push_data = product[POS_W-1:0];
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = odf_value;
    end else begin : g_tail
      assign cell_din[k] = cell_value[k-1];
    end

    opp_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX        (k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (accept),
      .clear  (last_frame),
      .din    (cell_din[k]),
      .center (center),
      .window (window),
      .value  (cell_value[k]),
      .pass   (cell_pass[k])
    );
  end

  opp_out_buf #(
    .W (POS_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (onset_position)
  );

endmodule
